>>> design/pds_pkg.sv
// Package for the pulse duration stretcher.
// Holds the fixed field widths, register indexes and the configuration type.
// No dependencies.
package pds_pkg;

  localparam int TICK_W = 15;
  localparam int SCALE_W = 16;
  localparam int PROD_W = TICK_W + SCALE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV = 2'd1;

  typedef struct packed {
    logic [SCALE_W-1:0] mult;
    logic [SCALE_W-1:0] div;
  } cfg_t;

endpackage

>>> design/pds_in_if.sv
// Input channel of the pulse duration stretcher: one pulse per transfer.
// Depends on pds_pkg for the field widths.
interface pds_in_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pulse_level;
  logic [TICK_W-1:0] pulse_ticks;
  logic              source_done;

  modport source (output valid, output pulse_level, output pulse_ticks,
                  output source_done, input ready);
  modport sink (input valid, input pulse_level, input pulse_ticks,
                input source_done, output ready);
endinterface

>>> design/pds_out_if.sv
// Result channel of the pulse duration stretcher: one chunk per transfer.
// Depends on pds_pkg for the field widths.
interface pds_out_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chunk_level;
  logic [TICK_W-1:0] chunk_ticks;
  logic              run_last;
  logic              stream_end;
  logic              clipped;

  modport source (output valid, output chunk_level, output chunk_ticks,
                  output run_last, output stream_end, output clipped, input ready);
  modport sink (input valid, input chunk_level, input chunk_ticks,
                input run_last, input stream_end, input clipped, output ready);
endinterface

>>> design/pds_sub.sv
// Shared subtract-and-compare unit of the pulse duration stretcher.
// No dependencies; used by pds_seq for divide steps and chunk cutting.
module pds_sub #(
  parameter int W = 22
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  logic [W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule

>>> design/pds_seq.sv
// Sequencer and datapath of the pulse duration stretcher.
// Depends on pds_pkg, pds_in_if, pds_out_if and pds_sub.
module pds_seq import pds_pkg::*; #(
  parameter int MAX_CHUNKS = 64,
  parameter int CHUNK_MAX_TICKS = 32767
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  pds_in_if.sink in_ch,
  pds_out_if.source out_ch
);

  localparam int CAP = MAX_CHUNKS * CHUNK_MAX_TICKS;
  localparam int REM_W = $clog2(CAP + 1);
  localparam int ALU_W = (REM_W > SCALE_W + 1) ? REM_W : SCALE_W + 1;
  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);
  localparam logic [TICK_W-1:0] CHUNK_T = TICK_W'(CHUNK_MAX_TICKS);
  localparam logic [PROD_W-1:0] CAP_P = PROD_W'(CAP);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CLIP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [SCALE_W-1:0] prem_r, prem_nxt;
  logic [REM_W-1:0]   left_r, left_nxt;
  logic               level_r, level_nxt;
  logic               done_r, done_nxt;
  logic               clip_r, clip_nxt;

  logic [SCALE_W:0] trial;
  logic [ALU_W-1:0] op_a, op_b, diff;
  logic             borrow;
  logic             last;

  assign trial = {prem_r, prod_r[PROD_W-1]};

  // Steer the shared unit: divide step or chunk cut.
  always_comb begin
    if (state_r == ST_DIV) begin
      op_a = ALU_W'(trial);
      op_b = ALU_W'(cfg.div);
    end else begin
      op_a = ALU_W'(left_r);
      op_b = ALU_W'(CHUNK_T);
    end
  end

  pds_sub #(.W(ALU_W)) u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  assign last = borrow || (diff == '0);

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.chunk_level = level_r;
  assign out_ch.chunk_ticks = borrow ? TICK_W'(left_r) : CHUNK_T;
  assign out_ch.run_last    = last;
  assign out_ch.stream_end  = last && done_r;
  assign out_ch.clipped     = clip_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    prem_nxt  = prem_r;
    left_nxt  = left_r;
    level_nxt = level_r;
    done_nxt  = done_r;
    clip_nxt  = clip_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          prod_nxt  = PROD_W'(in_ch.pulse_ticks);
          level_nxt = in_ch.pulse_level;
          done_nxt  = in_ch.source_done;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(prod_r[TICK_W-1:0]) * PROD_W'(cfg.mult);
        prem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Restoring step; quotient bits shift in behind the dividend.
        prem_nxt = borrow ? trial[SCALE_W-1:0] : diff[SCALE_W-1:0];
        prod_nxt = {prod_r[PROD_W-2:0], ~borrow};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_CLIP;
        end
      end
      ST_CLIP: begin
        clip_nxt  = (prod_r > CAP_P);
        left_nxt  = (prod_r > CAP_P) ? REM_W'(CAP) : prod_r[REM_W-1:0];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          left_nxt = last ? '0 : diff[REM_W-1:0];
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      left_r  <= '0;
      level_r <= 1'b0;
      done_r  <= 1'b0;
      clip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      level_r <= level_nxt;
      done_r  <= done_nxt;
      clip_r  <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    prem_r <= prem_nxt;
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("pds_seq: ready while a pulse is in work");

  a_free_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.run_last) |=> in_ch.ready)
    else $error("pds_seq: not ready after the final chunk");

  a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.run_last) |-> (out_ch.chunk_ticks == CHUNK_T))
    else $error("pds_seq: non-final chunk is not full");

  a_left_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (left_r <= REM_W'(CAP)))
    else $error("pds_seq: remaining ticks above the cap");

endmodule

>>> design/pulse_duration_stretcher_unit.sv
// Top level of the pulse duration stretcher: configuration registers and
// the sequencer. Depends on pds_pkg, pds_in_if, pds_out_if and pds_seq.
//
//  channel  | direction | handshake    | payload
//  ---------+-----------+--------------+------------------------------------
//  in_ch    | in        | valid/ready  | pulse_level, pulse_ticks, source_done
//  out_ch   | out       | valid/ready  | chunk_level, chunk_ticks, run_last,
//           |           |              | stream_end, clipped
//  cfg_*    | in        | write enable | cfg_idx, cfg_wdata
//
// A pulse is taken in idle, multiplied, then scaled by the 31-step restoring
// divide that runs on the one shared subtractor, clipped to the cap and cut
// into 1 to MAX_CHUNKS chunks, one chunk per cycle while the result side is ready.
// Reset is synchronous, active low; it returns the sequencer to idle and the
// scale registers to 1. A stall on the result side holds the current chunk;
// the input side stays not ready until the final chunk of the run transfers.
module pulse_duration_stretcher_unit import pds_pkg::*; #(
  parameter int MAX_CHUNKS = 64,
  parameter int CHUNK_MAX_TICKS = 32767
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SCALE_W-1:0]   cfg_wdata,
  pds_in_if.sink               in_ch,
  pds_out_if.source            out_ch
);

  cfg_t cfg_r, cfg_nxt;

  // Take a register write; drop writes to unknown indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MULT: cfg_nxt.mult = cfg_wdata;
        CFG_DIV:  cfg_nxt.div  = cfg_wdata;
        default:  cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mult <= SCALE_W'(1);
      cfg_r.div  <= SCALE_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A zero divisor needs no special path: the restoring divide then
  // yields an all-ones quotient, which always lands above the cap.
  pds_seq #(
    .MAX_CHUNKS      (MAX_CHUNKS),
    .CHUNK_MAX_TICKS (CHUNK_MAX_TICKS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> verif/pulse_duration_stretcher_unit_tb.sv
// Self-checking testbench for pulse_duration_stretcher_unit: random pulses and scale
// settings, with chunk runs predicted in the bench and checked in order.
// Depends on pds_pkg, pds_in_if, pds_out_if and the unit itself.
module pulse_duration_stretcher_unit_tb;
  import pds_pkg::*;

  localparam int MAX_CHUNKS = 64;
  localparam int CHUNK_MAX_TICKS = 32767;
  localparam int RANDOM_PHASES = 10;
  localparam int PULSES_PER_PHASE = 42;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_LIMIT = 10;

  // Indexes that decode to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] ticks;
    logic              done;
  } pulse_t;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] ticks;
    logic              run_last;
    logic              stream_end;
    logic              clipped;
  } chunk_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SCALE_W-1:0] cfg_wdata;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pulse_duration_stretcher_unit #(
    .MAX_CHUNKS     (MAX_CHUNKS),
    .CHUNK_MAX_TICKS(CHUNK_MAX_TICKS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Bench copy of the scale registers, updated as each write is issued.
  logic [SCALE_W-1:0] mult_reg;
  logic [SCALE_W-1:0] div_reg;

  pulse_t pulse_backlog[$];   // pulses waiting to be offered
  chunk_t pending_chunks[$];  // chunks predicted but not yet seen

  bit in_taken;   // a pulse transferred at the last rising edge
  bit quiet;      // no idling on either side
  int in_gap;
  int out_gap;
  int flaws;
  int stall_cycles;

  always begin
    #5 clk = ~clk;
  end

  // Scale one pulse and queue the run of chunks it must produce.
  function automatic void stretch_pulse(pulse_t p);
    logic [31:0] cap;
    logic [31:0] prod;
    logic [31:0] span;
    logic [31:0] part;
    logic        sat;
    chunk_t      c;
    int          n;
    cap = MAX_CHUNKS * CHUNK_MAX_TICKS;
    prod = 32'(p.ticks) * 32'(mult_reg);
    // A zero divisor reads as an all-ones quotient, so it always saturates.
    if (div_reg == '0) begin
      span = cap + 1;
    end else begin
      span = prod / 32'(div_reg);
    end
    sat = span > cap;
    if (sat) begin
      span = cap;
    end
    n = 0;
    // Emit full chunks first; a zero span still yields one zero-tick terminator.
    do begin
      part = (span > CHUNK_MAX_TICKS) ? CHUNK_MAX_TICKS : span;
      span = span - part;
      c.level = p.level;
      c.ticks = part[TICK_W-1:0];
      c.run_last = (span == 0);
      c.stream_end = (span == 0) && p.done;
      c.clipped = sat;
      pending_chunks.push_back(c);
      n++;
    end while (span != 0 && n < MAX_CHUNKS);
  endfunction

  // Input driver: offer the head of the backlog, hold it until it transfers,
  // and drop valid for short random bursts between pulses.
  always @(negedge clk) begin
    pulse_t nxt;
    if (in_taken) begin
      void'(pulse_backlog.pop_front());
    end
    if (in_ch.valid && !in_taken) begin
      // hold the offered pulse
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pulse_backlog.size() != 0 && (quiet || $urandom_range(0, 5) != 0)) begin
      nxt = pulse_backlog[0];
      in_ch.valid <= 1'b1;
      in_ch.pulse_level <= nxt.level;
      in_ch.pulse_ticks <= nxt.ticks;
      in_ch.source_done <= nxt.done;
    end else begin
      if (pulse_backlog.size() != 0) begin
        in_gap = $urandom_range(0, 3);
      end
      in_ch.valid <= 1'b0;
    end
  end

  // Result side backpressure: random bursts with ready low.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on every pulse transfer, check every chunk transfer
  // against the oldest prediction.
  always @(posedge clk) begin
    pulse_t p;
    chunk_t got;
    chunk_t want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      p.level = in_ch.pulse_level;
      p.ticks = in_ch.pulse_ticks;
      p.done = in_ch.source_done;
      stretch_pulse(p);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.level = out_ch.chunk_level;
      got.ticks = out_ch.chunk_ticks;
      got.run_last = out_ch.run_last;
      got.stream_end = out_ch.stream_end;
      got.clipped = out_ch.clipped;
      if (pending_chunks.size() == 0) begin
        flaws++;
        if (flaws <= REPORT_LIMIT) begin
          $display("unexpected chunk: level %0b ticks %0d last %0b end %0b clip %0b",
                   got.level, got.ticks, got.run_last, got.stream_end, got.clipped);
        end
      end else begin
        want = pending_chunks.pop_front();
        if (got !== want) begin
          flaws++;
          if (flaws <= REPORT_LIMIT) begin
            $display("chunk mismatch: expected level %0b ticks %0d last %0b end %0b clip %0b",
                     want.level, want.ticks, want.run_last, want.stream_end, want.clipped);
            $display("                got      level %0b ticks %0d last %0b end %0b clip %0b",
                     got.level, got.ticks, got.run_last, got.stream_end, got.clipped);
          end
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer or register write.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Write one register and mirror it; spare indexes leave both registers alone.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    if (idx == CFG_MULT) begin
      mult_reg = data;
    end else if (idx == CFG_DIV) begin
      div_reg = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scale(logic [SCALE_W-1:0] mult, logic [SCALE_W-1:0] div);
    write_reg(CFG_MULT, mult);
    write_reg(CFG_DIV, div);
  endtask

  // Wait until every pulse has transferred and every chunk has come back,
  // then let the unit return to idle.
  task automatic drain();
    while (pulse_backlog.size() != 0 || in_ch.valid || pending_chunks.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic add_pulse(logic level, logic [TICK_W-1:0] ticks, logic done);
    pulse_t p;
    p.level = level;
    p.ticks = ticks;
    p.done = done;
    pulse_backlog.push_back(p);
  endtask

  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(0, 3))
      0: return TICK_W'($urandom_range(0, 7));
      1: return TICK_W'($urandom_range(CHUNK_MAX_TICKS - 7, CHUNK_MAX_TICKS));
      default: return TICK_W'($urandom);
    endcase
  endfunction

  // Pick a scale setting: fully random or moderate, with clipping, tiny results,
  // extremes and the zero divisor mixed in.
  task automatic random_scale();
    logic [SCALE_W-1:0] m;
    logic [SCALE_W-1:0] d;
    case ($urandom_range(0, 6))
      0: begin
        m = SCALE_W'($urandom_range(1, 8));
        d = SCALE_W'($urandom_range(1, 8));
      end
      1: begin
        m = SCALE_W'($urandom_range(1, 4));
        d = SCALE_W'($urandom);
      end
      2: begin
        m = SCALE_W'($urandom_range(1024, 65535));
        d = SCALE_W'($urandom_range(1, 4));
      end
      3: begin
        m = ($urandom_range(0, 1) != 0) ? '1 : SCALE_W'(1);
        d = ($urandom_range(0, 1) != 0) ? '1 : SCALE_W'(1);
      end
      4: begin
        m = SCALE_W'($urandom);
        d = '0;
      end
      default: begin
        m = SCALE_W'($urandom);
        d = SCALE_W'($urandom);
      end
    endcase
    // Occasionally poke a spare index; the unit must ignore it.
    if ($urandom_range(0, 3) == 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                SCALE_W'($urandom));
    end
    set_scale(m, d);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MULT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pulse_level = 1'b0;
    in_ch.pulse_ticks = '0;
    in_ch.source_done = 1'b0;
    out_ch.ready = 1'b0;
    mult_reg = SCALE_W'(1);
    div_reg = SCALE_W'(1);
    in_taken = 1'b0;
    quiet = 1'b0;
    in_gap = 0;
    out_gap = 0;
    flaws = 0;
    stall_cycles = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset scale is 1/1: zero-tick terminators, extremes and bit patterns.
    add_pulse(1'b1, '0, 1'b0);
    add_pulse(1'b0, '0, 1'b1);
    add_pulse(1'b1, TICK_W'(1), 1'b0);
    add_pulse(1'b1, TICK_W'(CHUNK_MAX_TICKS), 1'b1);
    add_pulse(1'b0, 15'h5555, 1'b0);
    add_pulse(1'b1, 15'h2aaa, 1'b1);
    drain();

    // Doubling: an exact two-chunk run, and one full chunk plus a remainder.
    set_scale(SCALE_W'(2), SCALE_W'(1));
    add_pulse(1'b1, TICK_W'(CHUNK_MAX_TICKS), 1'b1);
    add_pulse(1'b0, TICK_W'(16384), 1'b0);
    drain();

    // Scale by the chunk count: full scale lands exactly on the cap unclipped.
    set_scale(SCALE_W'(MAX_CHUNKS), SCALE_W'(1));
    add_pulse(1'b1, TICK_W'(CHUNK_MAX_TICKS), 1'b1);
    add_pulse(1'b0, TICK_W'(CHUNK_MAX_TICKS - 1), 1'b0);
    drain();

    // Largest multiplier: saturation with the clipped flag.
    set_scale('1, SCALE_W'(1));
    add_pulse(1'b0, TICK_W'(CHUNK_MAX_TICKS), 1'b1);
    add_pulse(1'b1, TICK_W'(1), 1'b0);
    drain();

    // Largest multiplier over largest divisor is the identity.
    set_scale('1, '1);
    add_pulse(1'b1, TICK_W'(CHUNK_MAX_TICKS), 1'b0);
    add_pulse(1'b0, '0, 1'b1);
    drain();

    // Zero divisor saturates even a zero product; spare writes must not stick.
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    set_scale('0, '0);
    add_pulse(1'b1, '0, 1'b1);
    add_pulse(1'b0, TICK_W'(CHUNK_MAX_TICKS), 1'b0);
    drain();

    // Tiny ratio: everything truncates toward zero.
    set_scale(SCALE_W'(1), '1);
    add_pulse(1'b1, TICK_W'(CHUNK_MAX_TICKS), 1'b1);
    add_pulse(1'b0, TICK_W'(12345), 1'b0);
    drain();

    // Random phases, each under a fresh scale setting; the last one runs
    // with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_scale();
      if (ph == RANDOM_PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int k = 0; k < PULSES_PER_PHASE; k++) begin
        add_pulse(1'($urandom), pick_ticks(), $urandom_range(0, 5) == 0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (flaws == 0 && pending_chunks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
